// ===== rtl/channel_frequency_slot_select_assert.svh =====
// ----------------------------------------------------------------------------
// channel frequency slot select assertion macros
// concurrent check helpers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef CHANNEL_FREQUENCY_SLOT_SELECT_ASSERT_SVH
`define CHANNEL_FREQUENCY_SLOT_SELECT_ASSERT_SVH

`ifndef SYNTHESIS

// property must hold on every clock outside reset
`define CFSS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cfss check failed");

// expression must never be true outside reset
`define CFSS_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  `CFSS_ASSERT(lbl, clk, rst_n, !(expr))

`else

`define CFSS_ASSERT(lbl, clk, rst_n, prop)
`define CFSS_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ===== rtl/cfss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfss_pkg
// shared types, band and preset tables for channel frequency slot select
// ----------------------------------------------------------------------------
package cfss_pkg;

  // field widths
  localparam int unsigned HASH_W  = 32;
  localparam int unsigned FREQ_W  = 30;
  localparam int unsigned BW_W    = 19;
  localparam int unsigned SLOT_W  = 8;
  localparam int unsigned PROD_W  = SLOT_W + BW_W;
  localparam int unsigned OVR_W   = 16;

  localparam logic [HASH_W-1:0] HASH_SEED = 32'd5381;

  // remainder unit retires one dividend bit per cycle
  localparam int unsigned REM_STEPS = HASH_W;
  localparam int unsigned CNT_W     = $clog2(REM_STEPS);

  // configuration register indexes
  localparam logic [1:0] REG_REGION   = 2'd0;
  localparam logic [1:0] REG_PRESET   = 2'd1;
  localparam logic [1:0] REG_OVERRIDE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_FIN
  } state_t;

  // hash register control
  typedef struct packed {
    logic step;
    logic reload;
  } hash_ctl_t;

  // remainder unit control and status
  typedef struct packed {
    logic              start;
    logic [HASH_W-1:0] dividend;
    logic [SLOT_W-1:0] divisor;
  } rem_ctl_t;

  typedef struct packed {
    logic              busy;
    logic [SLOT_W-1:0] remainder;
  } rem_sts_t;

  // djb2 step
  function automatic logic [HASH_W-1:0] djb2_step(input logic [HASH_W-1:0] h,
                                                  input logic [7:0] b);
    return (h << 5) + h + {24'd0, b};
  endfunction

  // hash of a label packed right-justified, evaluated at elaboration only
  function automatic logic [HASH_W-1:0] label_hash_f(input logic [79:0] s, input int n);
    logic [HASH_W-1:0] h;
    h = HASH_SEED;
    for (int i = n - 1; i >= 0; i--) begin
      h = djb2_step(h, s[i*8 +: 8]);
    end
    return h;
  endfunction

  localparam logic [HASH_W-1:0] LH_LONG_FAST   = label_hash_f("LongFast", 8);
  localparam logic [HASH_W-1:0] LH_LONG_SLOW   = label_hash_f("LongSlow", 8);
  localparam logic [HASH_W-1:0] LH_MEDIUM_SLOW = label_hash_f("MediumSlow", 10);
  localparam logic [HASH_W-1:0] LH_MEDIUM_FAST = label_hash_f("MediumFast", 10);
  localparam logic [HASH_W-1:0] LH_SHORT_SLOW  = label_hash_f("ShortSlow", 9);
  localparam logic [HASH_W-1:0] LH_SHORT_FAST  = label_hash_f("ShortFast", 9);
  localparam logic [HASH_W-1:0] LH_LONG_MOD    = label_hash_f("LongMod", 7);
  localparam logic [HASH_W-1:0] LH_SHORT_TURBO = label_hash_f("ShortTurbo", 10);

  // preset display-name hash
  function automatic logic [HASH_W-1:0] label_hash(input logic [2:0] p);
    logic [HASH_W-1:0] h;
    unique case (p)
      3'd0:    h = LH_LONG_FAST;
      3'd1:    h = LH_LONG_SLOW;
      3'd2:    h = LH_MEDIUM_SLOW;
      3'd3:    h = LH_MEDIUM_FAST;
      3'd4:    h = LH_SHORT_SLOW;
      3'd5:    h = LH_SHORT_FAST;
      3'd6:    h = LH_LONG_MOD;
      default: h = LH_SHORT_TURBO;
    endcase
    return h;
  endfunction

  // preset bandwidth in hz
  function automatic logic [BW_W-1:0] preset_bw(input logic [2:0] p);
    logic [BW_W-1:0] bw;
    unique case (p)
      3'd1, 3'd6: bw = 19'd125000;
      3'd7:       bw = 19'd500000;
      default:    bw = 19'd250000;
    endcase
    return bw;
  endfunction

  function automatic logic [3:0] preset_sf(input logic [2:0] p);
    logic [3:0] sf;
    unique case (p)
      3'd0:    sf = 4'd11;
      3'd1:    sf = 4'd12;
      3'd2:    sf = 4'd10;
      3'd3:    sf = 4'd9;
      3'd4:    sf = 4'd8;
      3'd5:    sf = 4'd7;
      3'd6:    sf = 4'd11;
      default: sf = 4'd7;
    endcase
    return sf;
  endfunction

  function automatic logic [3:0] preset_cr(input logic [2:0] p);
    return (p == 3'd1 || p == 3'd6) ? 4'd8 : 4'd5;
  endfunction

  // slots per band, band span over bandwidth, floored, at least one
  function automatic logic [SLOT_W-1:0] slot_count(input logic [1:0] r, input logic [2:0] p);
    logic [SLOT_W-1:0] c;
    logic [BW_W-1:0]   bw;
    bw = preset_bw(p);
    unique case (r)
      2'd0:    c = (bw == 19'd125000) ? 8'd208 : (bw == 19'd500000) ? 8'd52 : 8'd104;
      2'd1:    c = (bw == 19'd125000) ? 8'd2   : 8'd1;
      2'd2:    c = (bw == 19'd125000) ? 8'd8   : (bw == 19'd500000) ? 8'd2  : 8'd4;
      default: c = (bw == 19'd125000) ? 8'd104 : (bw == 19'd500000) ? 8'd26 : 8'd52;
    endcase
    return c;
  endfunction

  // centre of the lowest slot: band start plus half a bandwidth
  function automatic logic [FREQ_W-1:0] slot_base(input logic [1:0] r, input logic [2:0] p);
    logic [FREQ_W-1:0] start;
    unique case (r)
      2'd0:    start = 30'd902000000;
      2'd1:    start = 30'd869400000;
      2'd2:    start = 30'd433000000;
      default: start = 30'd915000000;
    endcase
    return start + {11'd0, preset_bw(p) >> 1};
  endfunction

endpackage

// ===== rtl/cfss_hash.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfss_hash
// running djb2 hash over name bytes, reloaded at the end of each name
// ----------------------------------------------------------------------------
module cfss_hash import cfss_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  hash_ctl_t         ctl,
  input  logic [7:0]        name_byte,
  output logic [HASH_W-1:0] hash_next
);

  logic [HASH_W-1:0] hash_r, hash_nxt;

  // next hash with this beat's byte folded in
  assign hash_next = djb2_step(hash_r, name_byte);

  always_comb begin
    hash_nxt = hash_r;
    priority if (ctl.reload) begin
      hash_nxt = HASH_SEED;
    end else if (ctl.step) begin
      hash_nxt = hash_next;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= HASH_SEED;
    end else begin
      hash_r <= hash_nxt;
    end
  end

endmodule

// ===== rtl/cfss_rem_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfss_rem_unit
// bit-serial restoring remainder, one dividend bit per cycle
// ----------------------------------------------------------------------------
module cfss_rem_unit import cfss_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  rem_ctl_t ctl,
  output rem_sts_t sts
);

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(REM_STEPS - 1);

  logic [HASH_W-1:0] shift_r, shift_nxt;
  logic [SLOT_W-1:0] div_r, div_nxt;
  logic [SLOT_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic [SLOT_W:0]   trial, diff;
  logic              fits;

  // shared subtract and compare
  assign trial = {rem_r, shift_r[HASH_W-1]};
  assign diff  = trial - {1'b0, div_r};
  assign fits  = trial >= {1'b0, div_r};

  always_comb begin
    shift_nxt = shift_r;
    div_nxt   = div_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    priority if (ctl.start) begin
      shift_nxt = ctl.dividend;
      div_nxt   = ctl.divisor;
      rem_nxt   = '0;
      cnt_nxt   = '0;
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      rem_nxt   = fits ? diff[SLOT_W-1:0] : trial[SLOT_W-1:0];
      shift_nxt = shift_r << 1;
      cnt_nxt   = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    div_r   <= div_nxt;
    rem_r   <= rem_nxt;
  end

  assign sts.busy      = busy_r;
  assign sts.remainder = rem_r;

endmodule

// ===== rtl/channel_frequency_slot_select.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// channel_frequency_slot_select
// hashes a channel name and picks its frequency slot for region and preset
// ----------------------------------------------------------------------------
//  channel  dir  handshake              beat
//  in_      in   in_valid / in_ready    one name byte with last and empty marks
//  out_     out  out_valid / out_ready  frequency, bandwidth, sf, cr, slot, count
//  cfg_     in   cfg_valid / cfg_ready  register index and write data
//
//  a name byte that does not end the name is folded into the hash and leaves the block idle
//  a name-ending beat holds off the next input beat while it is accepted, runs
//  through the bit-serial remainder unit, waits to see it finish, is multiplied
//  and then loads the output
//  a result still waiting in the output register holds the load, and the input
//  stalls with it; reset is synchronous, active low; configuration is accepted every cycle
// ----------------------------------------------------------------------------
module channel_frequency_slot_select import cfss_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_name_byte,
  input  logic              in_is_last,
  input  logic              in_name_empty,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [FREQ_W-1:0] out_slot_freq,
  output logic [BW_W-1:0]   out_chan_bw,
  output logic [3:0]        out_spread_fac,
  output logic [3:0]        out_cr_denom,
  output logic [SLOT_W-1:0] out_slot_index,
  output logic [SLOT_W-1:0] out_channel_count,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [OVR_W-1:0]  cfg_data
);

`include "channel_frequency_slot_select_assert.svh"

  state_t            state_r, state_nxt;
  logic [1:0]        region_r;
  logic [2:0]        preset_r;
  logic [OVR_W-1:0]  override_r;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              load_out;
  logic [FREQ_W-1:0] freq_r;
  logic [BW_W-1:0]   bw_r;
  logic [3:0]        sf_r, cr_r;
  logic [SLOT_W-1:0] slot_r, count_r;
  logic              in_beat, ends_name;
  logic [HASH_W-1:0] hash_next;
  logic [OVR_W-1:0]  override_m1;
  hash_ctl_t         hash_ctl;
  rem_ctl_t          rem_ctl;
  rem_sts_t          rem_sts;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_r   <= '0;
      preset_r   <= '0;
      override_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_REGION:   region_r   <= cfg_data[1:0];
        REG_PRESET:   preset_r   <= cfg_data[2:0];
        REG_OVERRIDE: override_r <= cfg_data;
        default:      ;
      endcase
    end
  end

  // input beat
  assign in_ready  = (state_r == ST_IDLE);
  assign in_beat   = in_valid && in_ready;
  assign ends_name = in_is_last || in_name_empty;

  assign hash_ctl.step   = in_beat && !ends_name;
  assign hash_ctl.reload = in_beat && ends_name;

  cfss_hash u_hash (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (hash_ctl),
    .name_byte (in_name_byte),
    .hash_next (hash_next)
  );

  // dividend: override slot, preset label hash or name hash
  assign override_m1 = override_r - 1'b1;

  always_comb begin
    rem_ctl.start   = in_beat && ends_name;
    rem_ctl.divisor = slot_count(region_r, preset_r);
    priority if (override_r != '0) begin
      rem_ctl.dividend = {{(HASH_W-OVR_W){1'b0}}, override_m1};
    end else if (in_name_empty) begin
      rem_ctl.dividend = label_hash(preset_r);
    end else begin
      rem_ctl.dividend = hash_next;
    end
  end

  cfss_rem_unit u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (rem_ctl),
    .sts   (rem_sts)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r;
    load_out      = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (rem_ctl.start) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!rem_sts.busy) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt  = {{BW_W{1'b0}}, rem_sts.remainder} *
                    {{SLOT_W{1'b0}}, preset_bw(preset_r)};
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // product and result registers
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (load_out) begin
      freq_r  <= slot_base(region_r, preset_r) + FREQ_W'(prod_r);
      bw_r    <= preset_bw(preset_r);
      sf_r    <= preset_sf(preset_r);
      cr_r    <= preset_cr(preset_r);
      slot_r  <= rem_sts.remainder;
      count_r <= slot_count(region_r, preset_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_slot_freq     = freq_r;
  assign out_chan_bw       = bw_r;
  assign out_spread_fac    = sf_r;
  assign out_cr_denom      = cr_r;
  assign out_slot_index    = slot_r;
  assign out_channel_count = count_r;

  // checks
  `CFSS_ASSERT(a_idle_not_busy, clk, rst_n, in_ready |-> !rem_sts.busy)
  `CFSS_ASSERT(a_slot_in_range, clk, rst_n, out_valid |-> (out_slot_index < out_channel_count))
  `CFSS_ASSERT(a_start_runs, clk, rst_n, rem_ctl.start |=> (rem_sts.busy && state_r == ST_DIV))
  `CFSS_ASSERT_NEVER(a_load_over_result, clk, rst_n, load_out && out_valid_r && !out_ready)

endmodule
